// ===== design/ust_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ust_pkg;

    localparam int CP_W    = 21;
    localparam int COUNT_W = 3;
    localparam int STATE_W = 4;
    localparam int CLASS_W = 4;

    localparam logic [STATE_W-1:0] ST_ACCEPT = 4'd0;
    localparam logic [STATE_W-1:0] ST_REJECT = 4'd1;
    localparam logic [STATE_W-1:0] ST_COUNT  = 4'd9;

    localparam logic [CP_W-1:0] CP_RESET = 21'h00FFFD;
    localparam logic [CP_W-1:0] CP_MAX   = 21'h10FFFF;

    localparam logic [7:0] LEAD_MASK = 8'hFF;
    localparam logic [5:0] CONT_MASK = 6'h3F;

    typedef logic [CLASS_W-1:0] t_cls;
    typedef logic [STATE_W-1:0] t_state;

    typedef struct packed {
        logic [7:0] data_byte;
        t_cls       cls;
        logic       slice_end;
    } t_item;

    typedef struct packed {
        logic [CP_W-1:0]    code_point;
        logic [COUNT_W-1:0] bytes_used;
        logic               is_invalid;
    } t_res;

    localparam t_state NEXT_TBL [0:8][0:15] = '{
        '{4'd0, 4'd1, 4'd2, 4'd3, 4'd5, 4'd8, 4'd7, 4'd1,
          4'd1, 4'd1, 4'd4, 4'd6, 4'd1, 4'd1, 4'd1, 4'd1},
        '{4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1,
          4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1},
        '{4'd1, 4'd0, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd0,
          4'd1, 4'd0, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1},
        '{4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2,
          4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1},
        '{4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2,
          4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1},
        '{4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1,
          4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1},
        '{4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd3,
          4'd1, 4'd3, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1},
        '{4'd1, 4'd3, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd3,
          4'd1, 4'd3, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1},
        '{4'd1, 4'd3, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1,
          4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1}
    };

    function automatic t_cls byte_class(input logic [7:0] b);
        t_cls c;
        case (b) inside
            [8'h00:8'h7F]: c = 4'd0;
            [8'h80:8'h8F]: c = 4'd1;
            [8'h90:8'h9F]: c = 4'd9;
            [8'hA0:8'hBF]: c = 4'd7;
            [8'hC0:8'hC1]: c = 4'd8;
            [8'hC2:8'hDF]: c = 4'd2;
            8'hE0:         c = 4'd10;
            [8'hE1:8'hEC]: c = 4'd3;
            8'hED:         c = 4'd4;
            [8'hEE:8'hEF]: c = 4'd3;
            8'hF0:         c = 4'd11;
            [8'hF1:8'hF3]: c = 4'd6;
            8'hF4:         c = 4'd5;
            default:       c = 4'd8;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== design/ust_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ust_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic                  o_empty,
    output logic [WIDTH-1:0]      o_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR  = AW'(DEPTH - 1);
    localparam logic [CW-1:0] DEPTH_CNT = CW'(DEPTH);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [AW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count, n_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == DEPTH_CNT);
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

// ===== design/ust_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ust_front (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_push,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_slice_end,
    output logic             o_full,
    output logic             o_q_push,
    output ust_pkg::t_item   o_item,
    input  wire logic        i_q_full
);

    import ust_pkg::*;

    logic  r_valid, n_valid;
    t_item r_item;
    logic  take, drain;

    assign o_full   = r_valid && i_q_full;
    assign take     = i_push && !o_full;
    assign drain    = r_valid && !i_q_full;
    assign o_q_push = r_valid;
    assign o_item   = r_item;

    always_comb begin
        n_valid = r_valid;
        if (take) begin
            n_valid = 1'b1;
        end else if (drain) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_item.data_byte <= i_data_byte;
            r_item.cls       <= byte_class(i_data_byte);
            r_item.slice_end <= i_slice_end;
        end
    end

endmodule

`default_nettype wire

// ===== design/ust_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ust_back (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_q_empty,
    input  wire ust_pkg::t_item           i_item,
    output logic                          o_q_pop,
    input  wire logic                     i_out_full,
    output logic                          o_out_push,
    output ust_pkg::t_res                 o_res,
    input  wire logic [ust_pkg::CP_W-1:0] i_invalid_cp
);

    import ust_pkg::*;

    t_state             r_state, n_state;
    logic [CP_W-1:0]    r_partial, n_partial;
    logic [COUNT_W-1:0] r_count, n_count;
    logic               step;
    t_state             ns;
    logic [CP_W-1:0]    pv;
    logic [COUNT_W-1:0] cnt;
    logic [7:0]         lead;

    assign step    = !i_q_empty && !i_out_full;
    assign o_q_pop = step;

    always_comb begin
        lead = (LEAD_MASK >> i_item.cls) & i_item.data_byte;
        if (r_state != ST_ACCEPT) begin
            pv = {r_partial[CP_W-7:0], i_item.data_byte[5:0] & CONT_MASK};
        end else begin
            pv = {{(CP_W-8){1'b0}}, lead};
        end
        ns  = (r_state < ST_COUNT) ? NEXT_TBL[r_state][i_item.cls] : ST_REJECT;
        cnt = r_count + 1'b1;

        o_res.code_point = pv;
        o_res.bytes_used = cnt;
        o_res.is_invalid = 1'b0;
        o_out_push       = 1'b0;
        n_state          = r_state;
        n_partial        = r_partial;
        n_count          = r_count;

        if (step) begin
            if (ns == ST_ACCEPT) begin
                o_out_push = 1'b1;
            end else if (ns == ST_REJECT || i_item.slice_end) begin
                o_out_push       = 1'b1;
                o_res.code_point = i_invalid_cp;
                o_res.is_invalid = 1'b1;
            end
            if (o_out_push) begin
                n_state   = ST_ACCEPT;
                n_partial = '0;
                n_count   = '0;
            end else begin
                n_state   = ns;
                n_partial = pv;
                n_count   = cnt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_ACCEPT;
            r_partial <= '0;
            r_count   <= '0;
        end else begin
            r_state   <= n_state;
            r_partial <= n_partial;
            r_count   <= n_count;
        end
    end

endmodule

`default_nettype wire

// ===== design/utf8_stream_decoder.sv =====
// utf8_stream_decoder: validating utf-8 decoder, one byte per item
// input queue side: i_data_byte and i_slice_end are taken when push is high
// and full is low; i_slice_end marks the last byte of a slice
// result queue side: while empty is low the oldest result is on o_code_point,
// o_bytes_used and o_is_invalid; pop takes it
// a result enters the result queue once its final byte has passed the classify
// register and the byte queue; bytes inside a sequence give no result, malformed
// or cut-short sequences give the invalid code point with o_is_invalid set
// throughput is one byte per cycle while the result queue has room, set by the
// state update in the back end; a classify register and a small queue sit in
// front of it and a small result queue behind it
// when pop stays low the result queue fills, then the byte queue, then full
// rises; no item is lost
// register 0 (address 0) holds the invalid code point, 21 bits, reset 0xfffd;
// write it only while the decoder is idle
// synchronous reset empties all queues and returns the decoder to the accept
// state
`timescale 1ns / 1ps
`default_nettype none

module utf8_stream_decoder #(
    parameter int MID_DEPTH = 2,
    parameter int OUT_DEPTH = 2
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_slice_end,
    output logic             empty,
    input  wire logic        pop,
    output logic [20:0]      o_code_point,
    output logic [2:0]       o_bytes_used,
    output logic             o_is_invalid,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    import ust_pkg::*;

    localparam int ITEM_W = $bits(t_item);
    localparam int RES_W  = $bits(t_res);

    logic [CP_W-1:0] r_icp;
    logic            cfg_sel;

    logic              mid_push, mid_full, mid_empty, mid_pop;
    t_item             front_item, mid_item;
    logic [ITEM_W-1:0] mid_data;
    logic              out_push, out_full;
    t_res              back_res, out_res;
    logic [RES_W-1:0]  out_data;

    assign pready  = 1'b1;
    assign cfg_sel = (paddr[2] == 1'b0);
    assign prdata  = cfg_sel ? {{(32-CP_W){1'b0}}, r_icp} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_icp <= CP_RESET;
        end else if (psel && penable && pwrite && pready && cfg_sel) begin
            r_icp <= pwdata[CP_W-1:0];
        end
    end

    ust_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_data_byte (i_data_byte),
        .i_slice_end (i_slice_end),
        .o_full      (full),
        .o_q_push    (mid_push),
        .o_item      (front_item),
        .i_q_full    (mid_full)
    );

    ust_fifo #(
        .WIDTH (ITEM_W),
        .DEPTH (MID_DEPTH)
    ) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (mid_push),
        .i_data  (front_item),
        .o_full  (mid_full),
        .i_pop   (mid_pop),
        .o_empty (mid_empty),
        .o_data  (mid_data)
    );

    assign mid_item = t_item'(mid_data);

    ust_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_empty    (mid_empty),
        .i_item       (mid_item),
        .o_q_pop      (mid_pop),
        .i_out_full   (out_full),
        .o_out_push   (out_push),
        .o_res        (back_res),
        .i_invalid_cp (r_icp)
    );

    ust_fifo #(
        .WIDTH (RES_W),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (out_push),
        .i_data  (back_res),
        .o_full  (out_full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (out_data)
    );

    assign out_res      = t_res'(out_data);
    assign o_code_point = out_res.code_point;
    assign o_bytes_used = out_res.bytes_used;
    assign o_is_invalid = out_res.is_invalid;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_bytes_used != 3'd0 && o_bytes_used <= 3'd4))
        else $error("result byte count out of range");

    a_valid_scalar: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_is_invalid) |-> (o_code_point <= CP_MAX))
        else $error("accepted code point above the unicode range");

    a_single_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_is_invalid && o_bytes_used == 3'd1) |-> (o_code_point <= 21'h7F))
        else $error("single byte result outside ascii");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (!full && empty))
        else $error("queues not empty after reset");

endmodule

`default_nettype wire
